>>> hdl/wmp_pkg.sv
`default_nettype none

package wmp_pkg;

  // Sizing of the comparison.
  localparam int BLOCK_SIZE  = 16;
  localparam int COUNT_WIDTH = 16;

  // Fixed field widths.
  localparam int BASE_W  = 8;
  localparam int START_W = 16;
  localparam int LIMIT_W = 18;
  localparam int OUT_W   = 16;

  // Derived widths.
  localparam int POS_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam int BA_W  = $clog2(BLOCK_SIZE + 1);
  localparam int PEN_W = (COUNT_WIDTH + 2 > LIMIT_W) ? COUNT_WIDTH + 2 : LIMIT_W;

  // The wildcard base, ASCII 'N'.
  localparam logic [BASE_W-1:0] WILDCARD = 8'd78;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [POS_W-1:0]       POS_LAST  = POS_W'(BLOCK_SIZE - 1);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base_a;
    logic [BASE_W-1:0]  base_b;
    logic               first;
    logic               last;
    logic [START_W-1:0] start_mismatches;
    logic [START_W-1:0] start_ambiguous;
    logic [LIMIT_W-1:0] penalty_limit;
  } in_item_t;

  typedef struct packed {
    logic             passed;
    logic [OUT_W-1:0] mismatches;
    logic [OUT_W-1:0] ambiguous;
  } out_item_t;

  // Classification of one base pair.
  typedef struct packed {
    logic wild;
    logic mismatch;
  } pair_class_t;

  // Clip a start value to the counter range.
  function automatic count_t clip_start(input logic [START_W-1:0] v);
    logic [COUNT_WIDTH+START_W-1:0] ext;
    logic [COUNT_WIDTH+START_W-1:0] top;
    ext = {{COUNT_WIDTH{1'b0}}, v};
    top = {{START_W{1'b0}}, COUNT_MAX};
    if (ext > top) begin
      return COUNT_MAX;
    end
    return ext[COUNT_WIDTH-1:0];
  endfunction

  // Low bits of a count as carried on the result.
  function automatic logic [OUT_W-1:0] out_count(input count_t v);
    logic [COUNT_WIDTH+OUT_W-1:0] ext;
    ext = {{OUT_W{1'b0}}, v};
    return ext[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/wmp_pair_class.sv
`default_nettype none

module wmp_pair_class (
  input  wire logic [wmp_pkg::BASE_W-1:0] base_a,
  input  wire logic [wmp_pkg::BASE_W-1:0] base_b,
  output wmp_pkg::pair_class_t            pair_class
);
  import wmp_pkg::*;

  // A wildcard on either side makes the pair ambiguous, never a mismatch.
  always_comb begin
    pair_class.wild     = (base_a == WILDCARD) || (base_b == WILDCARD);
    pair_class.mismatch = !pair_class.wild && (base_a != base_b);
  end

endmodule

`default_nettype wire

>>> hdl/wmp_tracker.sv
`default_nettype none

module wmp_tracker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire wmp_pkg::in_item_t item,
  input  wire wmp_pkg::pair_class_t pair_class,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output wmp_pkg::out_item_t     out_data
);
  import wmp_pkg::*;

  count_t             mismatch_total, mismatch_total_next;
  count_t             ambiguous_total, ambiguous_total_next;
  logic [BA_W-1:0]    block_ambiguous, block_ambiguous_next;
  logic [POS_W-1:0]   block_position, block_position_next;
  logic [LIMIT_W-1:0] limit_held, limit_held_next;
  logic               aborted, aborted_next;
  logic               emit;
  logic               emit_pass;

  logic [COUNT_WIDTH:0] mm_sum;
  logic [COUNT_WIDTH:0] amb_sum;
  logic [PEN_W-1:0]     penalty;
  logic                 block_end;

  // The pipeline moves whenever the result register is free or being drained.
  assign advance = !out_valid || !out_stall;

  // Per-pair update of the running counts and the block check.
  always_comb begin
    mismatch_total_next  = mismatch_total;
    ambiguous_total_next = ambiguous_total;
    block_ambiguous_next = block_ambiguous;
    block_position_next  = block_position;
    limit_held_next      = limit_held;
    aborted_next         = aborted;
    emit                 = 1'b0;
    emit_pass            = 1'b0;
    mm_sum               = '0;
    amb_sum              = '0;
    penalty              = '0;
    block_end            = 1'b0;

    if (item.first) begin
      mismatch_total_next  = clip_start(item.start_mismatches);
      ambiguous_total_next = clip_start(item.start_ambiguous);
      limit_held_next      = item.penalty_limit;
      block_ambiguous_next = '0;
      block_position_next  = '0;
      aborted_next         = 1'b0;
    end

    if (aborted_next) begin
      // Skip pairs until the last one, which closes the aborted comparison.
      if (item.last) begin
        aborted_next         = 1'b0;
        block_ambiguous_next = '0;
        block_position_next  = '0;
      end
    end else begin
      if (pair_class.wild) begin
        block_ambiguous_next = block_ambiguous_next + BA_W'(1);
      end else if (pair_class.mismatch) begin
        mm_sum = {1'b0, mismatch_total_next} + (COUNT_WIDTH+1)'(1);
        mismatch_total_next = mm_sum[COUNT_WIDTH] ? COUNT_MAX : mm_sum[COUNT_WIDTH-1:0];
      end

      block_end = item.last || (block_position_next == POS_LAST);
      if (!block_end) begin
        block_position_next = block_position_next + POS_W'(1);
      end else begin
        block_position_next = '0;
        penalty = PEN_W'({mismatch_total_next, 1'b0}) + PEN_W'(ambiguous_total_next);
        if (penalty > PEN_W'(limit_held_next)) begin
          block_ambiguous_next = '0;
          aborted_next         = !item.last;
          emit                 = 1'b1;
        end else begin
          amb_sum = {1'b0, ambiguous_total_next} + (COUNT_WIDTH+1)'(block_ambiguous_next);
          ambiguous_total_next = amb_sum[COUNT_WIDTH] ? COUNT_MAX
                                                      : amb_sum[COUNT_WIDTH-1:0];
          block_ambiguous_next = '0;
          emit                 = item.last;
          emit_pass            = 1'b1;
        end
      end
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch_total  <= '0;
      ambiguous_total <= '0;
      block_ambiguous <= '0;
      block_position  <= '0;
      limit_held      <= '0;
      aborted         <= 1'b0;
      out_valid       <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid && emit;
      if (item_valid) begin
        mismatch_total  <= mismatch_total_next;
        ambiguous_total <= ambiguous_total_next;
        block_ambiguous <= block_ambiguous_next;
        block_position  <= block_position_next;
        limit_held      <= limit_held_next;
        aborted         <= aborted_next;
      end
    end
  end

  // Result payload, loaded only with a new result.
  always_ff @(posedge clk) begin
    if (advance && item_valid && emit) begin
      out_data.passed     <= emit_pass;
      out_data.mismatches <= out_count(mismatch_total_next);
      out_data.ambiguous  <= out_count(ambiguous_total_next);
    end
  end

endmodule

`default_nettype wire

>>> hdl/wildcard_mismatch_penalty_check.sv
// A result is registered: the item that causes it passes the input register, then the result register.
// Throughput: one pair per cycle; an input register and a result register
// part the two channels, so input stalls only while a result is held by out_stall.
// Reset (rst, synchronous): clears all counts, the held limit, the abort flag
// and both valid registers.
`default_nettype none

module wildcard_mismatch_penalty_check (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire wmp_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output wmp_pkg::out_item_t     out_data
);
  import wmp_pkg::*;

  logic        item_valid;
  in_item_t    item;
  logic        advance;
  logic        in_take;
  pair_class_t pair_class;

  // Input stage holds while the tracker is held by the output side.
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= in_data;
    end
  end

  wmp_pair_class u_class (
    .base_a     (item.base_a),
    .base_b     (item.base_b),
    .pair_class (pair_class)
  );

  wmp_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .pair_class (pair_class),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

>>> hdl/wmp_checker.sv
`default_nettype none

module wmp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire wmp_pkg::out_item_t out_data
);

  // Input stalls only when a result is waiting and held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind wildcard_mismatch_penalty_check wmp_checker u_wmp_checker (.*);

`default_nettype wire
